@@ src/hex_grid_cell_lookup_core_macros.svh @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: assertion macros
// Shared concurrent-check shorthands, clocked on aclk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_GRID_CELL_LOOKUP_CORE_MACROS_SVH
`define HEX_GRID_CELL_LOOKUP_CORE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define HGCL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define HGCL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/hgcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: package
// Field widths, register indexes, defaults and the configuration bundle.
// ----------------------------------------------------------------------------
package hgcl_pkg;

    // Default build parameters
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_TILES_DEF = 256;

    // Port field widths
    localparam int POS_W    = 16;
    localparam int TILES_W  = 9;
    localparam int INV_W    = 17;
    localparam int LOCAL_W  = 17;
    localparam int CENTER_W = 19;

    // Largest center coordinate, 2.0 in Q.16
    localparam int CENTER_MAX = 131072;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TILES_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TILES_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL    = 3'd4;

    // Reset values
    localparam logic [TILES_W-1:0] TILES_RST = 9'd1;
    localparam logic [INV_W-1:0]   INV_RST   = 17'h10000;

    // Register bank as seen by the pipeline stages
    typedef struct packed {
        logic [TILES_W-1:0] tiles_x;
        logic [TILES_W-1:0] tiles_y;
        logic [INV_W-1:0]   inv_tiles_x;
        logic [INV_W-1:0]   inv_tiles_y;
        logic               vertical;
    } cfg_t;

endpackage

@@ src/hgcl_scale.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: scale stage
// Converts the Q0.16 position to Q.FRAC_BITS and multiplies by the tile count.
// ----------------------------------------------------------------------------
module hgcl_scale #(
    parameter int FRAC_BITS = hgcl_pkg::FRAC_BITS_DEF,
    parameter int MAX_TILES = hgcl_pkg::MAX_TILES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  hgcl_pkg::cfg_t                         cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [hgcl_pkg::POS_W-1:0]             pos_x,
    input  logic [hgcl_pkg::POS_W-1:0]             pos_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [FRAC_BITS+$clog2(MAX_TILES+1)-1:0] qx,
    output logic [FRAC_BITS+$clog2(MAX_TILES+1)-1:0] qy
);
    import hgcl_pkg::*;

    localparam int TW   = $clog2(MAX_TILES + 1);
    localparam int QW   = FRAC_BITS + TW;
    localparam int XW   = POS_W + FRAC_BITS;
    localparam int SH_L = (FRAC_BITS >= POS_W) ? FRAC_BITS - POS_W : 0;
    localparam int SH_R = (FRAC_BITS <  POS_W) ? POS_W - FRAC_BITS : 0;

    logic                 valid_reg, valid_next;
    logic [QW-1:0]        qx_reg, qx_next;
    logic [QW-1:0]        qy_reg, qy_next;
    logic [FRAC_BITS-1:0] q_x, q_y;
    logic [TW-1:0]        eff_x, eff_y;

    // Clamp a tile count into 1..MAX_TILES
    function automatic logic [TW-1:0] eff_tiles(input logic [TILES_W-1:0] t);
        if (t == '0) begin
            return TW'(1);
        end else if (32'(t) > 32'(MAX_TILES)) begin
            return TW'(MAX_TILES);
        end else begin
            return TW'(t);
        end
    endfunction

    // Re-scale Q0.16 to Q.FRAC_BITS, truncating
    function automatic logic [FRAC_BITS-1:0] to_q(input logic [POS_W-1:0] p);
        return FRAC_BITS'((XW'(p) << SH_L) >> SH_R);
    endfunction

    // Scale both axes
    always_comb begin
        q_x     = to_q(pos_x);
        q_y     = to_q(pos_y);
        eff_x   = eff_tiles(cfg.tiles_x);
        eff_y   = eff_tiles(cfg.tiles_y);
        qx_next = {{TW{1'b0}}, q_x} * {{FRAC_BITS{1'b0}}, eff_x};
        qy_next = {{TW{1'b0}}, q_y} * {{FRAC_BITS{1'b0}}, eff_y};
    end

    // Advance when the slot is empty or drains this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
    end

    assign out_valid = valid_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;

endmodule

@@ src/hgcl_lattice.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: lattice stage
// Splits the scaled position on both lattices and squares the offsets.
// ----------------------------------------------------------------------------
module hgcl_lattice #(
    parameter int FRAC_BITS = hgcl_pkg::FRAC_BITS_DEF,
    parameter int MAX_TILES = hgcl_pkg::MAX_TILES_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [FRAC_BITS+$clog2(MAX_TILES+1)-1:0] qx,
    input  logic [FRAC_BITS+$clog2(MAX_TILES+1)-1:0] qy,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [FRAC_BITS-1:0]                     frac_x,
    output logic [FRAC_BITS-1:0]                     frac_y,
    output logic [2*FRAC_BITS-2:0]                   sqa_x,
    output logic [2*FRAC_BITS-2:0]                   sqb_x,
    output logic [2*FRAC_BITS-2:0]                   sqa_y,
    output logic [2*FRAC_BITS-2:0]                   sqb_y,
    output logic [$clog2(MAX_TILES+1)-1:0]           na_x,
    output logic [$clog2(MAX_TILES+1)-1:0]           nb_x,
    output logic [$clog2(MAX_TILES+1)-1:0]           na_y,
    output logic [$clog2(MAX_TILES+1)-1:0]           nb_y
);
    import hgcl_pkg::*;

    localparam int TW  = $clog2(MAX_TILES + 1);
    localparam int QW  = FRAC_BITS + TW;
    localparam int SQW = 2 * FRAC_BITS - 1;

    logic                 valid_reg, valid_next;
    logic [FRAC_BITS-1:0] frac_x_reg, frac_x_next, frac_y_reg, frac_y_next;
    logic [SQW-1:0]       sqa_x_reg, sqa_x_next, sqb_x_reg, sqb_x_next;
    logic [SQW-1:0]       sqa_y_reg, sqa_y_next, sqb_y_reg, sqb_y_next;
    logic [TW-1:0]        na_x_reg, na_x_next, nb_x_reg, nb_x_next;
    logic [TW-1:0]        na_y_reg, na_y_next, nb_y_reg, nb_y_next;

    // Square of a signed offset, taken through its magnitude
    function automatic logic [SQW-1:0] sq_of(input logic [FRAC_BITS-1:0] d);
        logic [FRAC_BITS-1:0]   mag;
        logic [2*FRAC_BITS-1:0] p;
        mag = d[FRAC_BITS-1] ? (~d + 1'b1) : d;
        p   = {{FRAC_BITS{1'b0}}, mag} * {{FRAC_BITS{1'b0}}, mag};
        return p[SQW-1:0];
    endfunction

    // Lattice A offset is frac - 1/2 (top bit flipped); lattice B offset is
    // frac read as signed. Lattice B's cell index carries when frac >= 1/2.
    always_comb begin
        frac_x_next = qx[FRAC_BITS-1:0];
        frac_y_next = qy[FRAC_BITS-1:0];
        sqa_x_next  = sq_of({~frac_x_next[FRAC_BITS-1], frac_x_next[FRAC_BITS-2:0]});
        sqb_x_next  = sq_of(frac_x_next);
        sqa_y_next  = sq_of({~frac_y_next[FRAC_BITS-1], frac_y_next[FRAC_BITS-2:0]});
        sqb_y_next  = sq_of(frac_y_next);
        na_x_next   = qx[QW-1:FRAC_BITS];
        na_y_next   = qy[QW-1:FRAC_BITS];
        nb_x_next   = na_x_next + TW'(frac_x_next[FRAC_BITS-1]);
        nb_y_next   = na_y_next + TW'(frac_y_next[FRAC_BITS-1]);
    end

    // Advance when the slot is empty or drains this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            frac_x_reg <= frac_x_next;
            frac_y_reg <= frac_y_next;
            sqa_x_reg  <= sqa_x_next;
            sqb_x_reg  <= sqb_x_next;
            sqa_y_reg  <= sqa_y_next;
            sqb_y_reg  <= sqb_y_next;
            na_x_reg   <= na_x_next;
            nb_x_reg   <= nb_x_next;
            na_y_reg   <= na_y_next;
            nb_y_reg   <= nb_y_next;
        end
    end

    assign out_valid = valid_reg;
    assign frac_x    = frac_x_reg;
    assign frac_y    = frac_y_reg;
    assign sqa_x     = sqa_x_reg;
    assign sqb_x     = sqb_x_reg;
    assign sqa_y     = sqa_y_reg;
    assign sqb_y     = sqb_y_reg;
    assign na_x      = na_x_reg;
    assign nb_x      = nb_x_reg;
    assign na_y      = na_y_reg;
    assign nb_y      = nb_y_reg;

endmodule

@@ src/hgcl_pick.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: pick stage
// Weights the squared offsets by the hexagon aspect and keeps the nearer cell.
// ----------------------------------------------------------------------------
module hgcl_pick #(
    parameter int FRAC_BITS = hgcl_pkg::FRAC_BITS_DEF,
    parameter int MAX_TILES = hgcl_pkg::MAX_TILES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  hgcl_pkg::cfg_t                         cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [FRAC_BITS-1:0]                   frac_x,
    input  logic [FRAC_BITS-1:0]                   frac_y,
    input  logic [2*FRAC_BITS-2:0]                 sqa_x,
    input  logic [2*FRAC_BITS-2:0]                 sqb_x,
    input  logic [2*FRAC_BITS-2:0]                 sqa_y,
    input  logic [2*FRAC_BITS-2:0]                 sqb_y,
    input  logic [$clog2(MAX_TILES+1)-1:0]         na_x,
    input  logic [$clog2(MAX_TILES+1)-1:0]         nb_x,
    input  logic [$clog2(MAX_TILES+1)-1:0]         na_y,
    input  logic [$clog2(MAX_TILES+1)-1:0]         nb_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [FRAC_BITS-1:0]                   d_x,
    output logic [FRAC_BITS-1:0]                   d_y,
    output logic [$clog2(MAX_TILES+1)-1:0]         n_x,
    output logic [$clog2(MAX_TILES+1)-1:0]         n_y,
    output logic                                   half
);
    import hgcl_pkg::*;

    localparam int TW  = $clog2(MAX_TILES + 1);
    localparam int SQW = 2 * FRAC_BITS - 1;
    localparam int DW  = SQW + 2;

    logic                 valid_reg, valid_next;
    logic [FRAC_BITS-1:0] d_x_reg, d_x_next, d_y_reg, d_y_next;
    logic [TW-1:0]        n_x_reg, n_x_next, n_y_reg, n_y_next;
    logic                 half_reg, half_next;
    logic [DW-1:0]        dist_a, dist_b;

    // Weight 1 or 3 on a squared offset
    function automatic logic [DW-1:0] weigh(input logic [SQW-1:0] s, input logic triple);
        logic [DW-1:0] w;
        w = DW'(s);
        return triple ? (w + (w << 1)) : w;
    endfunction

    // Compare distances; a tie goes to lattice B
    always_comb begin
        dist_a = weigh(sqa_x, !cfg.vertical) + weigh(sqa_y, cfg.vertical);
        dist_b = weigh(sqb_x, !cfg.vertical) + weigh(sqb_y, cfg.vertical);
        if (dist_a < dist_b) begin
            d_x_next  = {~frac_x[FRAC_BITS-1], frac_x[FRAC_BITS-2:0]};
            d_y_next  = {~frac_y[FRAC_BITS-1], frac_y[FRAC_BITS-2:0]};
            n_x_next  = na_x;
            n_y_next  = na_y;
            half_next = 1'b1;
        end else begin
            d_x_next  = frac_x;
            d_y_next  = frac_y;
            n_x_next  = nb_x;
            n_y_next  = nb_y;
            half_next = 1'b0;
        end
    end

    // Advance when the slot is empty or drains this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            d_x_reg  <= d_x_next;
            d_y_reg  <= d_y_next;
            n_x_reg  <= n_x_next;
            n_y_reg  <= n_y_next;
            half_reg <= half_next;
        end
    end

    assign out_valid = valid_reg;
    assign d_x       = d_x_reg;
    assign d_y       = d_y_reg;
    assign n_x       = n_x_reg;
    assign n_y       = n_y_reg;
    assign half      = half_reg;

endmodule

@@ src/hgcl_emit.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup: emit stage
// Normalizes the cell offset and maps the center back to UV; output register.
// ----------------------------------------------------------------------------
module hgcl_emit #(
    parameter int FRAC_BITS = hgcl_pkg::FRAC_BITS_DEF,
    parameter int MAX_TILES = hgcl_pkg::MAX_TILES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hgcl_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [FRAC_BITS-1:0]                  d_x,
    input  logic [FRAC_BITS-1:0]                  d_y,
    input  logic [$clog2(MAX_TILES+1)-1:0]        n_x,
    input  logic [$clog2(MAX_TILES+1)-1:0]        n_y,
    input  logic                                  half,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hgcl_pkg::LOCAL_W-1:0]          local_u,
    output logic [hgcl_pkg::LOCAL_W-1:0]          local_v,
    output logic signed [hgcl_pkg::CENTER_W-1:0]  center_u,
    output logic signed [hgcl_pkg::CENTER_W-1:0]  center_v
);
    import hgcl_pkg::*;

    localparam int TW   = $clog2(MAX_TILES + 1);
    localparam int PW   = TW + INV_W;
    localparam int XW   = FRAC_BITS + 18;
    localparam int SH_L = (FRAC_BITS <  16) ? 16 - FRAC_BITS : 0;
    localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int ONE  = 1 << FRAC_BITS;
    localparam int HALF = 1 << (FRAC_BITS - 1);
    localparam logic signed [FRAC_BITS+2:0] ONE_S  = (FRAC_BITS+3)'(ONE);
    localparam logic signed [FRAC_BITS+2:0] HALF_S = (FRAC_BITS+3)'(HALF);

    logic                       valid_reg, valid_next;
    logic [LOCAL_W-1:0]         local_u_reg, local_u_next, local_v_reg, local_v_next;
    logic signed [CENTER_W-1:0] center_u_reg, center_u_next;
    logic signed [CENTER_W-1:0] center_v_reg, center_v_next;

    // Offset to 0..1: short axis d + 1/2, long axis 3/2 d + 1/2, clamped
    function automatic logic [LOCAL_W-1:0] local_coord(input logic [FRAC_BITS-1:0] d,
                                                       input logic long_axis);
        logic signed [FRAC_BITS+2:0] dd;
        logic signed [FRAC_BITS+2:0] v;
        logic [XW-1:0]               vx;
        dd = {{3{d[FRAC_BITS-1]}}, d};
        if (long_axis) begin
            v = dd + (dd <<< 1) + ONE_S;
            if (v <= 0) begin
                v = '0;
            end else begin
                v = v >>> 1;
            end
        end else begin
            v = dd + HALF_S;
            if (v < 0) begin
                v = '0;
            end
        end
        if (v > ONE_S) begin
            v = ONE_S;
        end
        vx = XW'(v[FRAC_BITS:0]);
        return LOCAL_W'((vx << SH_L) >> SH_R);
    endfunction

    // Center n + h/2 cells times reciprocal: n*inv + (h ? inv/2 : 0), saturated
    function automatic logic [CENTER_W-1:0] center_uv(input logic [TW-1:0] n,
                                                      input logic h,
                                                      input logic [INV_W-1:0] inv);
        logic [PW-1:0] prod;
        logic [PW:0]   sum;
        prod = PW'(n) * PW'(inv);
        sum  = (PW+1)'(prod) + (h ? (PW+1)'(inv >> 1) : '0);
        if (sum > (PW+1)'(CENTER_MAX)) begin
            sum = (PW+1)'(CENTER_MAX);
        end
        return CENTER_W'(sum);
    endfunction

    always_comb begin
        local_u_next  = local_coord(d_x, !cfg.vertical);
        local_v_next  = local_coord(d_y, cfg.vertical);
        center_u_next = center_uv(n_x, half, cfg.inv_tiles_x);
        center_v_next = center_uv(n_y, half, cfg.inv_tiles_y);
    end

    // Hold the result beat until the receiver takes it
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            local_u_reg  <= local_u_next;
            local_v_reg  <= local_v_next;
            center_u_reg <= center_u_next;
            center_v_reg <= center_v_next;
        end
    end

    assign out_valid = valid_reg;
    assign local_u   = local_u_reg;
    assign local_v   = local_v_reg;
    assign center_u  = center_u_reg;
    assign center_v  = center_v_reg;

endmodule

@@ src/hex_grid_cell_lookup_core.sv @@
// ----------------------------------------------------------------------------
// Hex grid cell lookup core
// Finds the hexagon cell holding a UV position on a two-lattice tiling.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry one Q0.16 position, s_pos_x/s_pos_y.
//   Result beats (m_valid/m_ready) carry the normalized offset inside the
//   cell (m_local_u/m_local_v, 0..1 in Q.16) and the cell center in UV space
//   (m_center_u/m_center_v, signed Q.16).
//   Registers are written through cfg_we/cfg_index/cfg_wdata;
//   write them only while no beat is in flight. Unknown indexes are ignored.
//   Stages in order: scale multiply, lattice split and squares, nearest
//   cell pick, then normalize and center multiply into the output register.
//   Throughput is one beat per cycle while m_ready stays high; every stage
//   is a single register stage with its own valid bit.
//   Reset clears all valid bits and loads tile counts 1, reciprocals 1.0 and
//   vertical orientation.
//   When m_ready is low the result holds; empty stages keep filling, so up to
//   four beats are taken before s_ready drops.
// ----------------------------------------------------------------------------
module hex_grid_cell_lookup_core #(
    parameter int FRAC_BITS = hgcl_pkg::FRAC_BITS_DEF,
    parameter int MAX_TILES = hgcl_pkg::MAX_TILES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration
    input  logic                                  cfg_we,
    input  logic [hgcl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hgcl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Position beats
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [hgcl_pkg::POS_W-1:0]            s_pos_x,
    input  logic [hgcl_pkg::POS_W-1:0]            s_pos_y,
    // Result beats
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hgcl_pkg::LOCAL_W-1:0]          m_local_u,
    output logic [hgcl_pkg::LOCAL_W-1:0]          m_local_v,
    output logic signed [hgcl_pkg::CENTER_W-1:0]  m_center_u,
    output logic signed [hgcl_pkg::CENTER_W-1:0]  m_center_v
);
    import hgcl_pkg::*;

    localparam int TW  = $clog2(MAX_TILES + 1);
    localparam int QW  = FRAC_BITS + TW;
    localparam int SQW = 2 * FRAC_BITS - 1;

    cfg_t cfg_reg, cfg_next;

    logic                 sc_valid, sc_ready;
    logic [QW-1:0]        sc_qx, sc_qy;
    logic                 lt_valid, lt_ready;
    logic [FRAC_BITS-1:0] lt_frac_x, lt_frac_y;
    logic [SQW-1:0]       lt_sqa_x, lt_sqb_x, lt_sqa_y, lt_sqb_y;
    logic [TW-1:0]        lt_na_x, lt_nb_x, lt_na_y, lt_nb_y;
    logic                 pk_valid, pk_ready;
    logic [FRAC_BITS-1:0] pk_d_x, pk_d_y;
    logic [TW-1:0]        pk_n_x, pk_n_y;
    logic                 pk_half;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_TILES_X:     cfg_next.tiles_x     = cfg_wdata[TILES_W-1:0];
                CFG_TILES_Y:     cfg_next.tiles_y     = cfg_wdata[TILES_W-1:0];
                CFG_INV_TILES_X: cfg_next.inv_tiles_x = cfg_wdata[INV_W-1:0];
                CFG_INV_TILES_Y: cfg_next.inv_tiles_y = cfg_wdata[INV_W-1:0];
                CFG_VERTICAL:    cfg_next.vertical    = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tiles_x     <= TILES_RST;
            cfg_reg.tiles_y     <= TILES_RST;
            cfg_reg.inv_tiles_x <= INV_RST;
            cfg_reg.inv_tiles_y <= INV_RST;
            cfg_reg.vertical    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hgcl_scale #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TILES (MAX_TILES)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .qx        (sc_qx),
        .qy        (sc_qy)
    );

    hgcl_lattice #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TILES (MAX_TILES)
    ) u_lattice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .qx        (sc_qx),
        .qy        (sc_qy),
        .out_valid (lt_valid),
        .out_ready (lt_ready),
        .frac_x    (lt_frac_x),
        .frac_y    (lt_frac_y),
        .sqa_x     (lt_sqa_x),
        .sqb_x     (lt_sqb_x),
        .sqa_y     (lt_sqa_y),
        .sqb_y     (lt_sqb_y),
        .na_x      (lt_na_x),
        .nb_x      (lt_nb_x),
        .na_y      (lt_na_y),
        .nb_y      (lt_nb_y)
    );

    hgcl_pick #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TILES (MAX_TILES)
    ) u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (lt_valid),
        .in_ready  (lt_ready),
        .frac_x    (lt_frac_x),
        .frac_y    (lt_frac_y),
        .sqa_x     (lt_sqa_x),
        .sqb_x     (lt_sqb_x),
        .sqa_y     (lt_sqa_y),
        .sqb_y     (lt_sqb_y),
        .na_x      (lt_na_x),
        .nb_x      (lt_nb_x),
        .na_y      (lt_na_y),
        .nb_y      (lt_nb_y),
        .out_valid (pk_valid),
        .out_ready (pk_ready),
        .d_x       (pk_d_x),
        .d_y       (pk_d_y),
        .n_x       (pk_n_x),
        .n_y       (pk_n_y),
        .half      (pk_half)
    );

    hgcl_emit #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TILES (MAX_TILES)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (pk_valid),
        .in_ready  (pk_ready),
        .d_x       (pk_d_x),
        .d_y       (pk_d_y),
        .n_x       (pk_n_x),
        .n_y       (pk_n_y),
        .half      (pk_half),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .local_u   (m_local_u),
        .local_v   (m_local_v),
        .center_u  (m_center_u),
        .center_v  (m_center_v)
    );

`include "hex_grid_cell_lookup_core_macros.svh"

    // Empty output register means every stage can take a beat
    `HGCL_ASSERT_IMPLIES(a_ready_when_drained, !m_valid, s_ready, "s_ready low with empty output")
    // Local coordinates never exceed 1.0
    `HGCL_ASSERT_IMPLIES(a_local_range, m_valid, (m_local_u <= 17'h10000) && (m_local_v <= 17'h10000), "local coordinate above 1.0")
    // Centers are never negative and saturate at 2.0
    `HGCL_ASSERT_IMPLIES(a_center_u_range, m_valid, !m_center_u[CENTER_W-1] && (m_center_u <= 19'sd131072), "center_u out of range")
    `HGCL_ASSERT_IMPLIES(a_center_v_range, m_valid, !m_center_v[CENTER_W-1] && (m_center_v <= 19'sd131072), "center_v out of range")

endmodule
